// File: sv/apm_pkg.sv
// Shared types, constants and the gain lookup for the autoranging power meter.
// Used by apm_mul, apm_div and autoranging_power_meter_top.
package apm_pkg;

  // Shared multiplier: unsigned magnitudes, sign handled by the sequencer.
  localparam int MUL_W  = 23;
  localparam int PROD_W = 2 * MUL_W;

  // Shared divider: a 48-bit dividend walked MSB first, one bit per cycle.
  localparam int DVD_W  = 48;
  localparam int STEP_W = 6;

  // The per-sample current quotient and the scaled voltage magnitude.
  localparam int QS_W = 18;
  localparam int VS_W = 12;

  localparam int CUR_W  = 11;
  localparam int VOLT_W = 12;
  localparam int VREF_W = 10;
  localparam int THR_W  = 11;
  localparam int PWR_W  = 31;
  localparam int GAIN_W = 3;
  localparam int GAIN_VAL_W = 5;

  localparam logic [STEP_W-1:0] DIV_STEPS_GAIN  = 6'd18;
  localparam logic [STEP_W-1:0] DIV_STEPS_POWER = 6'd48;

  // Q16.16 scale factors.
  localparam logic [MUL_W-1:0] K_INT_SCALE  = 23'd1056;
  localparam logic [MUL_W-1:0] K_EXT_SCALE  = 23'd6336633;
  localparam logic [MUL_W-1:0] K_VOLT_SCALE = 23'd82706;
  localparam logic [MUL_W-1:0] NEG_SLOPE    = 23'd3122;
  localparam logic [MUL_W-1:0] POS_SLOPE    = 23'd3032;
  // Intercept magnitudes; the negative branch intercept is -27.
  localparam logic [MUL_W-1:0] NEG_ICPT_MAG = 23'd27;
  localparam logic [MUL_W-1:0] POS_ICPT     = 23'd74;

  localparam logic [GAIN_W-1:0] GAIN_MIN = 3'd1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 3'd4;

  localparam logic [THR_W-1:0] UPPER_RESET = 11'd430;
  localparam logic [THR_W-1:0] LOWER_RESET = 11'd185;

  localparam logic [PWR_W-1:0] PWR_SAT = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_EXT   = 2'd0;
  localparam logic [1:0] CFG_IDX_UPPER = 2'd1;
  localparam logic [1:0] CFG_IDX_LOWER = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LOWERED = 2'd1,
    STAT_RAISED  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_SCALE_W,
    ST_VOLT,
    ST_VOLT_W,
    ST_DIV_W,
    ST_PROD,
    ST_ACC,
    ST_CLOSE,
    ST_PDIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  function automatic logic [GAIN_VAL_W-1:0] gain_of(input logic [GAIN_W-1:0] step);
    logic [GAIN_VAL_W-1:0] g;
    case (step)
      3'd0:    g = 5'd1;
      3'd1:    g = 5'd2;
      3'd2:    g = 5'd3;
      3'd3:    g = 5'd5;
      3'd4:    g = 5'd9;
      default: g = 5'd17;
    endcase
    return g;
  endfunction

endpackage

// File: sv/apm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on apm_pkg for operand and product widths.
module apm_mul
  import apm_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

// File: sv/apm_div.sv
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Depends on apm_pkg for the request struct and the dividend width.
module apm_div
  import apm_pkg::*;
#(
  parameter int DIVISOR_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DVD_W-1:0]     quotient
);

  logic                 busy_r;
  logic [STEP_W-1:0]    cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DVD_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dsr_r;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_diff;
  logic                 fits;
  logic [DIVISOR_W-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    fits     = (rem_sh >= {1'b0, dsr_r});
    rem_nxt  = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: sv/autoranging_power_meter_top.sv
// Autoranging power meter: each accepted sample runs an 18-step gain division in the
// shared one-bit-per-cycle divider, in internal and external mode alike. A skipped or
// overrange sample bypasses the multiplier and the divider. An item with last set adds
// a 48-step divider pass when a mean is formed, and waits while a stalled result holds
// the output register. Reset is synchronous, active low:
// gain step 4, internal mode, thresholds 430 and 185, window cleared, no result pending.
module autoranging_power_meter_top
  import apm_pkg::*;
#(
  parameter int MAX_SAMPLES = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [THR_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CUR_W-1:0]         in_current_sample,
  input  logic signed [VOLT_W-1:0] in_volt_sample,
  input  logic [CUR_W-1:0]         in_current_ref,
  input  logic [VREF_W-1:0]        in_volt_ref,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PWR_W-1:0]         out_power_mw,
  output logic [1:0]               out_status,
  output logic [GAIN_W-1:0]        out_gain_index
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  state_t state_r, state_nxt;

  logic              ext_mode_r;
  logic [THR_W-1:0]  upper_r;
  logic [THR_W-1:0]  lower_r;

  logic [GAIN_W-1:0] gain_step_r;
  logic [DVD_W-1:0]  energy_r;
  logic [CUR_W-1:0]  peak_r;
  logic [CW-1:0]     count_r;
  logic              aborted_r;

  logic              c_neg_r;
  logic [CUR_W-1:0]  c_mag_r;
  logic [VOLT_W-1:0] volt_r;
  logic [VREF_W-1:0] vref_r;
  logic              last_r;
  logic              vs_neg_r;
  logic [VS_W-1:0]   vs_mag_r;
  logic [QS_W-1:0]   ima_mag_r;
  logic [PWR_W-1:0]  power_r;
  status_t           status_r;

  logic              out_valid_r;
  logic [PWR_W-1:0]  out_power_r;
  status_t           out_status_r;
  logic [GAIN_W-1:0] out_gain_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  div_req_t          div_req;
  logic [DVD_W-1:0]  div_dividend;
  logic [CW-1:0]     div_divisor;
  logic              div_busy;
  logic [DVD_W-1:0]  div_quotient;

  logic [VOLT_W-1:0] c_in;
  logic [THR_W-1:0]  upper_eff, lower_eff;
  logic              skip, over, raise, close_div;
  logic [VOLT_W:0]   d_ext;
  logic [VS_W-1:0]   d_mag, vmag_int;
  logic [DVD_W-1:0]  prod_ext, addend, energy_mag;

  apm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  apm_div #(
    .DIVISOR_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_comb begin
    c_in      = {1'b0, in_current_sample} - {1'b0, in_current_ref};
    upper_eff = ext_mode_r ? (upper_r >> 1) : upper_r;
    lower_eff = ext_mode_r ? (lower_r >> 1) : lower_r;
    skip      = aborted_r || (count_r >= CW'(MAX_SAMPLES));
    over      = !c_neg_r && (c_mag_r > upper_eff) && (gain_step_r > GAIN_MIN);
    raise     = (peak_r < lower_eff) && (gain_step_r < GAIN_MAX);
    close_div = !aborted_r && !raise && (count_r != '0);
    d_ext     = {volt_r[VOLT_W-1], volt_r} - {3'b000, vref_r};
    d_mag     = d_ext[VOLT_W] ? VS_W'(-d_ext) : VS_W'(d_ext);
    vmag_int  = volt_r[VOLT_W-1] ? VS_W'(-volt_r) : volt_r;
    prod_ext  = DVD_W'(mul_p);
    addend    = (c_neg_r ^ vs_neg_r) ? (-prod_ext) : prod_ext;
    energy_mag = energy_r[DVD_W-1] ? (-energy_r) : energy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state and the operands of the shared multiplier and divider.
  always_comb begin
    state_nxt    = state_r;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = CW'(gain_of(gain_step_r));
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (skip || over) begin
          state_nxt = last_r ? ST_CLOSE : ST_IDLE;
        end else begin
          mul_a     = MUL_W'(c_mag_r);
          mul_b     = ext_mode_r ? K_EXT_SCALE : (c_neg_r ? NEG_SLOPE : POS_SLOPE);
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (ext_mode_r) begin
          div_req.start = 1'b1;
          div_req.steps = DIV_STEPS_GAIN;
          div_dividend  = {mul_p[QS_W+15:16], {(DVD_W-QS_W){1'b0}}};
          state_nxt     = ST_VOLT;
        end else begin
          // Piecewise linear term, then the Q16.16 current scale.
          mul_a     = mul_p[MUL_W-1:0] + (c_neg_r ? NEG_ICPT_MAG : POS_ICPT);
          mul_b     = K_INT_SCALE;
          state_nxt = ST_SCALE_W;
        end
      end
      ST_SCALE_W: begin
        div_req.start = 1'b1;
        div_req.steps = DIV_STEPS_GAIN;
        div_dividend  = {mul_p[QS_W+15:16], {(DVD_W-QS_W){1'b0}}};
        state_nxt     = ST_VOLT;
      end
      ST_VOLT: begin
        mul_a     = MUL_W'(d_mag);
        mul_b     = K_VOLT_SCALE;
        state_nxt = ST_VOLT_W;
      end
      ST_VOLT_W: begin
        state_nxt = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (!div_busy) begin
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        mul_a     = MUL_W'(ima_mag_r);
        mul_b     = MUL_W'(vs_mag_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = last_r ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        if (close_div) begin
          div_req.start = 1'b1;
          div_req.steps = DIV_STEPS_POWER;
          div_dividend  = energy_mag;
          div_divisor   = count_r;
          state_nxt     = ST_PDIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PDIV: begin
        if (!div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r <= 1'b0;
      upper_r    <= UPPER_RESET;
      lower_r    <= LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_EXT:   ext_mode_r <= cfg_wdata[0];
        CFG_IDX_UPPER: upper_r    <= cfg_wdata;
        CFG_IDX_LOWER: lower_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sample capture and the per-step results of the shared units.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        c_neg_r <= c_in[VOLT_W-1];
        c_mag_r <= c_in[VOLT_W-1] ? CUR_W'(-c_in) : c_in[CUR_W-1:0];
        volt_r  <= in_volt_sample;
        vref_r  <= in_volt_ref;
        last_r  <= in_last;
      end
      ST_VOLT_W: begin
        vs_neg_r <= ext_mode_r ? d_ext[VOLT_W] : volt_r[VOLT_W-1];
        vs_mag_r <= ext_mode_r ? mul_p[VS_W+15:16] : vmag_int;
      end
      ST_DIV_W: begin
        ima_mag_r <= div_quotient[QS_W-1:0];
      end
      ST_CLOSE: begin
        power_r  <= '0;
        status_r <= aborted_r ? STAT_LOWERED : (raise ? STAT_RAISED : STAT_OK);
      end
      ST_PDIV: begin
        if (!div_busy) begin
          power_r <= (|div_quotient[DVD_W-1:PWR_W]) ? PWR_SAT : div_quotient[PWR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Window state and gain step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_step_r <= GAIN_MAX;
      energy_r    <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      aborted_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_EVAL: begin
          if (!skip) begin
            if (!c_neg_r && (c_mag_r > peak_r)) begin
              peak_r <= c_mag_r;
            end
            if (over) begin
              gain_step_r <= gain_step_r - 1'b1;
              aborted_r   <= 1'b1;
            end
          end
        end
        ST_ACC: begin
          energy_r <= energy_r + addend;
          count_r  <= count_r + 1'b1;
        end
        ST_CLOSE: begin
          if (!aborted_r && raise) begin
            gain_step_r <= gain_step_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            energy_r  <= '0;
            peak_r    <= '0;
            count_r   <= '0;
            aborted_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: a result waits here until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_power_r  <= power_r;
      out_status_r <= status_r;
      out_gain_r   <= gain_step_r;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_power_mw   = out_power_r;
  assign out_status     = out_status_r;
  assign out_gain_index = out_gain_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_step_r >= GAIN_MIN) && (gain_step_r <= GAIN_MAX))
    else $error("gain step left its range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("sample count passed the window limit");

  a_retry_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> (out_power_r == '0))
    else $error("retry result carries a nonzero power");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_EMIT) |-> !div_busy)
    else $error("divider still busy outside a computation");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for autoranging_power_meter_top: random sample windows,
// a bit-true predictor of gain stepping and mean power, and a scoreboard of readings.
// Depends on apm_pkg and autoranging_power_meter_top.
module tb_top;
  import apm_pkg::*;

  localparam int WINDOW_CAP = 128;
  localparam int ITEM_GOAL = 1150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 120;

  localparam longint INT_K = longint'(K_INT_SCALE);
  localparam longint EXT_K = longint'(K_EXT_SCALE);
  localparam longint VOLT_K = longint'(K_VOLT_SCALE);
  localparam longint NEG_K = longint'(NEG_SLOPE);
  localparam longint POS_K = longint'(POS_SLOPE);
  localparam longint NEG_OFFSET = -27;
  localparam longint POS_OFFSET = 74;

  typedef struct {
    logic [CUR_W-1:0]  cur;
    logic [VOLT_W-1:0] volt;
    logic [CUR_W-1:0]  cref;
    logic [VREF_W-1:0] vref;
    logic              last;
  } meter_sample_t;

  typedef struct {
    logic [PWR_W-1:0]  power;
    status_t           status;
    logic [GAIN_W-1:0] gain;
  } reading_t;

  typedef enum int {WIN_CLEAN, WIN_OVERRANGE, WIN_LOW_PEAK, WIN_NOISE} window_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_IDX_EXT;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CUR_W-1:0] in_current_sample = '0;
  logic signed [VOLT_W-1:0] in_volt_sample = '0;
  logic [CUR_W-1:0] in_current_ref = '0;
  logic [VREF_W-1:0] in_volt_ref = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PWR_W-1:0] out_power_mw;
  logic [1:0] out_status;
  logic [GAIN_W-1:0] out_gain_index;

  // Predictor state and its copy of the configuration registers.
  bit cfg_ext = 1'b0;
  int cfg_upper = 430;
  int cfg_lower = 185;
  int meter_gain = 4;
  logic [47:0] win_energy = '0;
  int win_peak = 0;
  int win_count = 0;
  bit win_aborted = 1'b0;

  meter_sample_t pending_samples[$];
  reading_t expected_readings[$];
  meter_sample_t held;
  int queued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  autoranging_power_meter_top #(.MAX_SAMPLES(WINDOW_CAP)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_current_sample(in_current_sample),
    .in_volt_sample(in_volt_sample),
    .in_current_ref(in_current_ref),
    .in_volt_ref(in_volt_ref),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_power_mw(out_power_mw),
    .out_status(out_status),
    .out_gain_index(out_gain_index)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int rand_between(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly short pauses, now and then a long one; none at all in a calm stretch.
  function automatic int idle_length(input bit calm);
    int r;
    r = int'($urandom_range(99));
    if (calm || r < 60) return 0;
    if (r < 90) return rand_between(1, 3);
    return rand_between(4, 40);
  endfunction

  // Advances the meter by one sample and tells whether it closes a window.
  function automatic void meter_take_sample(input meter_sample_t s, output bit emits,
                                            output reading_t r);
    int c, volt, up_e, lo_e;
    longint g, ima, vs, p, e, mag, pwr;
    emits = 1'b0;
    r.power = '0;
    r.status = STAT_OK;
    r.gain = '0;
    c = int'(s.cur) - int'(s.cref);
    volt = int'($signed(s.volt));
    up_e = cfg_ext ? (cfg_upper >> 1) : cfg_upper;
    lo_e = cfg_ext ? (cfg_lower >> 1) : cfg_lower;
    if (!win_aborted && win_count < WINDOW_CAP) begin
      if (c > 0 && c > win_peak) win_peak = c;
      if (c > up_e && meter_gain > int'(GAIN_MIN)) begin
        meter_gain--;
        win_aborted = 1'b1;
      end else begin
        case (meter_gain)
          1: g = 2;
          2: g = 3;
          3: g = 5;
          default: g = 9;
        endcase
        if (cfg_ext) begin
          ima = (longint'(c) * EXT_K) / (g * 65536);
          vs = (longint'(volt - int'(s.vref)) * VOLT_K) / 65536;
        end else begin
          p = (c < 0) ? longint'(c) * NEG_K + NEG_OFFSET : longint'(c) * POS_K + POS_OFFSET;
          ima = (p * INT_K) / (g * 65536);
          vs = volt;
        end
        win_energy = win_energy + 48'(ima * vs);
        win_count++;
      end
    end
    if (s.last) begin
      emits = 1'b1;
      if (win_aborted) begin
        r.status = STAT_LOWERED;
      end else if (win_peak < lo_e && meter_gain < int'(GAIN_MAX)) begin
        meter_gain++;
        r.status = STAT_RAISED;
      end else if (win_count != 0) begin
        e = longint'($signed(win_energy));
        mag = (e < 0) ? -e : e;
        pwr = mag / win_count;
        if (pwr > 2147483647) pwr = 2147483647;
        r.power = PWR_W'(pwr);
      end
      r.gain = GAIN_W'(meter_gain);
      win_energy = '0;
      win_peak = 0;
      win_count = 0;
      win_aborted = 1'b0;
    end
  endfunction

  // Queues one sample with the given offset current; the reference is picked so
  // that both raw values stay in range.
  task automatic add_sample(input int c, input int volt, input int vref, input bit last);
    meter_sample_t s;
    int cref;
    cref = rand_between((c < 0) ? -c : 0, (c > 0) ? 2047 - c : 2047);
    s.cref = CUR_W'(cref);
    s.cur = CUR_W'(cref + c);
    s.volt = VOLT_W'(volt);
    s.vref = VREF_W'(vref);
    s.last = last;
    pending_samples.push_back(s);
    queued_total++;
  endtask

  task automatic add_window(input window_kind_t kind, input int len, input bit open);
    int up_e, lo_e, key, c, i;
    bit last;
    up_e = cfg_ext ? (cfg_upper >> 1) : cfg_upper;
    lo_e = cfg_ext ? (cfg_lower >> 1) : cfg_lower;
    key = rand_between(0, len - 1);
    for (i = 0; i < len; i++) begin
      last = (i == len - 1) && !open;
      case (kind)
        WIN_CLEAN: c = (i == key) ? rand_between((lo_e < up_e) ? lo_e : up_e, up_e)
                                  : rand_between(-up_e, up_e);
        WIN_OVERRANGE: c = (i == key) ? rand_between((up_e < 2047) ? up_e + 1 : 2047, 2047)
                                      : rand_between(-up_e, up_e);
        WIN_LOW_PEAK: c = rand_between(-2047, (lo_e > 0) ? lo_e - 1 : 0);
        default: begin
          c = rand_between(-2047, 2047);
          if ($urandom_range(7) == 0) last = 1'b1;
        end
      endcase
      add_sample(c, rand_between(-2048, 2047), rand_between(0, 1023), last);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= THR_W'(val);
    case (idx)
      CFG_IDX_EXT: cfg_ext = val[0];
      CFG_IDX_UPPER: cfg_upper = val;
      CFG_IDX_LOWER: cfg_lower = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued sample has been taken and every reading has come back,
  // then lets the block finish any sample still in work.
  task automatic settle();
    while (accepted_total != queued_total || expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: holds the payload while stalled, otherwise pauses or sends the next item.
  always @(posedge clk) begin
    bit emits;
    reading_t rd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        meter_take_sample(held, emits, rd);
        if (emits) expected_readings.push_back(rd);
        accepted_total++;
        if ($urandom_range(79) == 0) send_calm = ~send_calm;
        send_gap = idle_length(send_calm);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          held = pending_samples.pop_front();
          in_current_sample <= held.cur;
          in_volt_sample <= held.volt;
          in_current_ref <= held.cref;
          in_volt_ref <= held.vref;
          in_last <= held.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random back-pressure.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading power %0d status %0d gain %0d", $time,
                 out_power_mw, out_status, out_gain_index);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_power_mw !== want.power) begin
          $display("%0t: power_mw expected %0d got %0d", $time, want.power, out_power_mw);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_gain_index !== want.gain) begin
          $display("%0t: gain_index expected %0d got %0d", $time, want.gain,
                   out_gain_index);
          mismatches++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(299) == 0) recv_calm = ~recv_calm;
      stall_left = idle_length(recv_calm);
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int phase_len, phase_items, len, r;
    bit cut;
    window_kind_t kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Three overranges walk the gain down to its lowest step; later samples are dropped.
    add_sample(2047, 2047, 1023, 1'b0);
    add_sample(-2047, -2048, 0, 1'b1);
    add_sample(2047, 0, 0, 1'b1);
    add_sample(431, 5, 0, 1'b1);
    // At the lowest gain an overrange sample is accumulated like any other.
    add_sample(2047, 2047, 1023, 1'b0);
    add_sample(-2047, -2048, 0, 1'b0);
    add_sample(0, 1000, 0, 1'b1);
    // A negative current never raises the peak; a low peak raises the gain.
    add_sample(-5, 700, 0, 1'b0);
    add_sample(184, -700, 0, 1'b1);
    add_sample(185, 300, 0, 1'b1);
    add_sample(430, -1, 0, 1'b1);
    // Switch to measured voltage in the middle of a window.
    add_sample(300, 1200, 0, 1'b0);
    settle();
    write_reg(CFG_IDX_EXT, 1);
    add_sample(200, -2048, 1023, 1'b0);
    add_sample(100, 2047, 0, 1'b1);
    settle();

    while (queued_total < ITEM_GOAL) begin
      write_reg(CFG_IDX_EXT, int'($urandom_range(1)));
      r = int'($urandom_range(99));
      write_reg(CFG_IDX_UPPER, (r < 12) ? 0 : (r < 24) ? 2047 : rand_between(250, 900));
      r = int'($urandom_range(99));
      write_reg(CFG_IDX_LOWER, (r < 12) ? 0 : (r < 20) ? 2047 : rand_between(40, 350));
      phase_len = rand_between(60, 160);
      if (phase_len > ITEM_GOAL - queued_total) phase_len = ITEM_GOAL - queued_total;
      phase_items = 0;
      cut = ($urandom_range(3) == 0);
      while (phase_items < phase_len) begin
        r = int'($urandom_range(99));
        kind = (r < 65) ? WIN_CLEAN : (r < 80) ? WIN_OVERRANGE :
               (r < 90) ? WIN_LOW_PEAK : WIN_NOISE;
        r = int'($urandom_range(99));
        len = (r < 85) ? rand_between(1, 12) : (r < 97) ? rand_between(13, 60)
                                                        : rand_between(128, 134);
        add_window(kind, len, cut && (phase_items + len >= phase_len));
        phase_items += len;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
